// ----- design/box_blur_line_pass_core_defines.svh -----
// Assertion macros used by the box blur line pass sequencer.
`ifndef BOX_BLUR_LINE_PASS_CORE_DEFINES_SVH
`define BOX_BLUR_LINE_PASS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on clk_i, off while rst_ni is low.
`define BBLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i, reset included.
`define BBLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BBLP_ASSERT(lbl, prop, msg)
`define BBLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- design/bblp_pkg.sv -----
// Types and constants of the box blur line pass core.
`default_nettype none

package bblp_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_RADIUS  = 40;
  localparam int unsigned CFG_BITS    = 6;
  localparam int unsigned POS_BITS    = 7;
  localparam int unsigned CNT_BITS    = POS_BITS + 1;
  localparam int unsigned NUM_LANES   = 3;

  localparam logic [POS_BITS-1:0] POS_LIMIT = POS_BITS'(127);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] red_in;
    logic [SAMPLE_BITS-1:0] green_in;
    logic [SAMPLE_BITS-1:0] blue_in;
    logic                   line_end_in;
  } pix_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] red_out;
    logic [SAMPLE_BITS-1:0] green_out;
    logic [SAMPLE_BITS-1:0] blue_out;
    logic                   run_end;
    logic                   line_end_out;
  } pix_out_t;

  // Sequencer to lanes
  typedef struct packed {
    logic wr_en;
    logic first_en;
    logic acc_clr;
    logic acc_add;
    logic use_first;
    logic div_load;
    logic div_step;
  } lane_ctl_t;

  // Sequencer to output merge
  typedef struct packed {
    logic load;
    logic run_end;
    logic line_end;
  } out_ctl_t;

endpackage

`default_nettype wire

// ----- design/bblp_lane.sv -----
// One channel lane: window memory, first sample, tap accumulator, serial divider.
`default_nettype none

module bblp_lane #(
  parameter int unsigned MaxRadius = bblp_pkg::MAX_RADIUS,
  localparam int unsigned Depth = 2 * MaxRadius + 1,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned RadW  = $clog2(MaxRadius + 1),
  localparam int unsigned DivW  = $clog2(2 * MaxRadius + 2)
) (
  input  wire                               clk_i,
  input  bblp_pkg::lane_ctl_t               ctl_i,
  input  wire  [AddrW-1:0]                  waddr_i,
  input  wire  [AddrW-1:0]                  raddr_i,
  input  wire  [RadW-1:0]                   radius_i,
  input  wire  [DivW-1:0]                   divisor_i,
  input  wire  [bblp_pkg::SAMPLE_BITS-1:0]  sample_i,
  output logic [bblp_pkg::SAMPLE_BITS-1:0]  quot_o
);
  import bblp_pkg::*;

  localparam int unsigned SumW = SAMPLE_BITS + DivW;

  logic [SAMPLE_BITS-1:0] mem [Depth];
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic [SAMPLE_BITS-1:0] first_q;
  logic [SAMPLE_BITS-1:0] tap;
  logic [SumW-1:0]        acc_q;
  logic [SumW-1:0]        dvd;
  logic [DivW-1:0]        prem_q;
  logic [SAMPLE_BITS-1:0] quo_q;
  logic [DivW:0]          trial;
  logic                   fits;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= sample_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // taps before line start read the first sample
  assign tap   = ctl_i.use_first ? first_q : rdata_q;
  // rounding bias: (sum + r) / (2r + 1)
  assign dvd   = acc_q + SumW'(radius_i);
  assign trial = {prem_q, quo_q[SAMPLE_BITS-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i) begin
    if (ctl_i.first_en) begin
      first_q <= sample_i;
    end
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc_add) begin
      acc_q <= acc_q + SumW'(tap);
    end
    // quotient fits SAMPLE_BITS, so the high part starts below the divisor
    if (ctl_i.div_load) begin
      prem_q <= dvd[SumW-1 -: DivW];
      quo_q  <= dvd[SAMPLE_BITS-1:0];
    end else if (ctl_i.div_step) begin
      prem_q <= fits ? DivW'(trial - {1'b0, divisor_i}) : trial[DivW-1:0];
      quo_q  <= {quo_q[SAMPLE_BITS-2:0], fits};
    end
  end

  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ----- design/bblp_ctrl.sv -----
// Sequencer: radius register, line position, window addressing, divider steps.
`default_nettype none
`include "box_blur_line_pass_core_defines.svh"

module bblp_ctrl #(
  parameter int unsigned MaxRadius = bblp_pkg::MAX_RADIUS,
  localparam int unsigned Depth = 2 * MaxRadius + 1,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned RadW  = $clog2(MaxRadius + 1),
  localparam int unsigned DivW  = $clog2(2 * MaxRadius + 2)
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [bblp_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  input  wire                            in_valid_i,
  input  wire                            in_line_end_i,
  output logic                           in_stall_o,
  input  wire                            out_free_i,
  output bblp_pkg::lane_ctl_t            lane_ctl_o,
  output logic [AddrW-1:0]               waddr_o,
  output logic [AddrW-1:0]               raddr_o,
  output logic [RadW-1:0]                radius_o,
  output logic [DivW-1:0]                divisor_o,
  output bblp_pkg::out_ctl_t             out_ctl_o
);
  import bblp_pkg::*;

  localparam int unsigned StepW = $clog2(SAMPLE_BITS);
  localparam logic [StepW-1:0] StepLast = StepW'(SAMPLE_BITS - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_TAPS = 6'b000010,
    ST_LAST = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [RadW-1:0]     radius_q, radius_wr;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [CNT_BITS-1:0] count_q, count_d, count_now;
  logic [AddrW-1:0]    head_q, head_d, head_nxt;
  logic [RadW-1:0]     center_q, center_d;
  logic [AddrW-1:0]    tap_q, tap_d;
  logic                flush_q, flush_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                rd_vld_q;
  logic                use_first_q, use_first_d;
  logic                in_acc;
  logic                r_lt_cnt;
  logic                tap_last;
  logic [AddrW:0]      tsum, r_ext, rsum;
  logic [AddrW-1:0]    tap_dist;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  assign radius_wr = (int'(cfg_wdata_i) > MaxRadius) ? RadW'(MaxRadius) : RadW'(cfg_wdata_i);

  assign count_now = {1'b0, pos_q} + CNT_BITS'(1);
  assign r_lt_cnt  = {{CNT_BITS{1'b0}}, radius_q} < {{RadW{1'b0}}, count_now};
  assign head_nxt  = (head_q == AddrW'(Depth - 1)) ? '0 : head_q + AddrW'(1);

  // tap distance from the newest sample, clamped at the line end
  assign tsum  = (AddrW + 1)'(center_q) + {1'b0, tap_q};
  assign r_ext = (AddrW + 1)'(radius_q);
  assign tap_dist = (tsum < r_ext) ? '0 : AddrW'(tsum - r_ext);
  assign use_first_d = {{CNT_BITS{1'b0}}, tap_dist} >= {{AddrW{1'b0}}, count_q};
  assign rsum  = {1'b0, head_q} + (AddrW + 1)'(Depth) - {1'b0, tap_dist};
  assign raddr_o = (head_q >= tap_dist) ? (head_q - tap_dist) : AddrW'(rsum);

  assign tap_last  = (tap_q == AddrW'({radius_q, 1'b0}));
  assign waddr_o   = head_nxt;
  assign radius_o  = radius_q;
  assign divisor_o = DivW'({radius_q, 1'b1});

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    count_d  = count_q;
    head_d   = head_q;
    center_d = center_q;
    tap_d    = tap_q;
    flush_d  = flush_q;
    step_d   = step_q;
    lane_ctl_o = '0;
    lane_ctl_o.acc_add   = rd_vld_q;
    lane_ctl_o.use_first = use_first_q;
    out_ctl_o = '0;
    out_ctl_o.run_end  = !flush_q || (center_q == '0);
    out_ctl_o.line_end = flush_q && (center_q == '0);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          lane_ctl_o.wr_en    = 1'b1;
          lane_ctl_o.first_en = (pos_q == '0);
          head_d  = head_nxt;
          count_d = count_now;
          flush_d = in_line_end_i;
          tap_d   = '0;
          if (in_line_end_i) begin
            pos_d    = '0;
            center_d = r_lt_cnt ? radius_q : RadW'(pos_q);
            state_d  = ST_TAPS;
          end else begin
            pos_d = (pos_q == POS_LIMIT) ? pos_q : pos_q + POS_BITS'(1);
            if (r_lt_cnt) begin
              center_d = radius_q;
              state_d  = ST_TAPS;
            end
          end
        end
      end
      ST_TAPS: begin
        lane_ctl_o.acc_clr = (tap_q == '0);
        tap_d = tap_q + AddrW'(1);
        if (tap_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        lane_ctl_o.div_load = 1'b1;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        lane_ctl_o.div_step = 1'b1;
        step_d = step_q + StepW'(1);
        if (step_q == StepLast) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          out_ctl_o.load = 1'b1;
          if (out_ctl_o.run_end) begin
            state_d = ST_IDLE;
          end else begin
            center_d = center_q - RadW'(1);
            tap_d    = '0;
            state_d  = ST_TAPS;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= RadW'(1);
      pos_q       <= '0;
      count_q     <= '0;
      head_q      <= '0;
      center_q    <= '0;
      tap_q       <= '0;
      flush_q     <= 1'b0;
      step_q      <= '0;
      rd_vld_q    <= 1'b0;
      use_first_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        radius_q <= radius_wr;
      end
      pos_q       <= pos_d;
      count_q     <= count_d;
      head_q      <= head_d;
      center_q    <= center_d;
      tap_q       <= tap_d;
      flush_q     <= flush_d;
      step_q      <= step_d;
      rd_vld_q    <= (state_q == ST_TAPS);
      use_first_q <= use_first_d;
    end
  end

  `BBLP_ASSERT(a_load_then_div, state_q == ST_LOAD |=> state_q == ST_DIV, "load without steps")
  `BBLP_ASSERT(a_flush_starts, in_acc && in_line_end_i |=> state_q == ST_TAPS, "no flush")
  `BBLP_ASSERT(a_line_end_idle, out_ctl_o.load && out_ctl_o.line_end |=> state_q == ST_IDLE, "flush overrun")
  `BBLP_ASSERT_ALWAYS(a_load_free, out_ctl_o.load |-> out_free_i, "result over untaken beat")

endmodule

`default_nettype wire

// ----- design/bblp_merge.sv -----
// Output stage: packs the three lane quotients and the run flags into one beat.
`default_nettype none

module bblp_merge (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  bblp_pkg::out_ctl_t                ctl_i,
  input  wire  [bblp_pkg::SAMPLE_BITS-1:0]  red_i,
  input  wire  [bblp_pkg::SAMPLE_BITS-1:0]  green_i,
  input  wire  [bblp_pkg::SAMPLE_BITS-1:0]  blue_i,
  input  wire                               out_stall_i,
  output logic                              out_free_o,
  output logic                              out_valid_o,
  output bblp_pkg::pix_out_t                out_data_o
);
  import bblp_pkg::*;

  logic     valid_q;
  pix_out_t data_q;

  assign out_free_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q.red_out      <= red_i;
      data_q.green_out    <= green_i;
      data_q.blue_out     <= blue_i;
      data_q.run_end      <= ctl_i.run_end;
      data_q.line_end_out <= ctl_i.line_end;
    end
  end

endmodule

`default_nettype wire

// ----- design/box_blur_line_pass_core.sv -----
// Top level of the box blur line pass: sequencer, three channel lanes, output merge.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_stall_o   bblp_pkg::pix_in_t
//   out       source     out_valid_o/out_stall_i bblp_pkg::pix_out_t
//   cfg       sink       cfg_we_i                cfg_wdata_i (window radius)
//
// A beat that produces no result leaves the sequencer idle. Each result takes
// 2r+1 window reads (one tap per cycle from each lane's window RAM), one drain,
// one divider load and 16 restoring-divide steps, then the handoff; a line end
// beat produces min(L, r+1) results back to back.
// Reset clears the sequencer, line position and radius (1); window RAM is not
// cleared, since every tap read was written earlier in the same line.
// A stalled output holds the sequencer in its handoff state; the last result of
// a beat sits in the output register while the next input beat is taken.
`default_nettype none

module box_blur_line_pass_core #(
  parameter int unsigned MaxRadius = bblp_pkg::MAX_RADIUS
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [bblp_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  bblp_pkg::pix_in_t              in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output bblp_pkg::pix_out_t             out_data_o
);
  import bblp_pkg::*;

  localparam int unsigned Depth = 2 * MaxRadius + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned RadW  = $clog2(MaxRadius + 1);
  localparam int unsigned DivW  = $clog2(2 * MaxRadius + 2);

  lane_ctl_t              lane_ctl;
  out_ctl_t               out_ctl;
  logic                   out_free;
  logic [AddrW-1:0]       waddr;
  logic [AddrW-1:0]       raddr;
  logic [RadW-1:0]        radius;
  logic [DivW-1:0]        divisor;
  logic [SAMPLE_BITS-1:0] lane_in  [NUM_LANES];
  logic [SAMPLE_BITS-1:0] lane_quo [NUM_LANES];

  // lane 0 red, 1 green, 2 blue
  assign lane_in[0] = in_data_i.red_in;
  assign lane_in[1] = in_data_i.green_in;
  assign lane_in[2] = in_data_i.blue_in;

  bblp_ctrl #(
    .MaxRadius (MaxRadius)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_line_end_i (in_data_i.line_end_in),
    .in_stall_o    (in_stall_o),
    .out_free_i    (out_free),
    .lane_ctl_o    (lane_ctl),
    .waddr_o       (waddr),
    .raddr_o       (raddr),
    .radius_o      (radius),
    .divisor_o     (divisor),
    .out_ctl_o     (out_ctl)
  );

  // all lanes run in lockstep off one sequencer
  for (genvar gi = 0; gi < NUM_LANES; gi++) begin : g_lane
    bblp_lane #(
      .MaxRadius (MaxRadius)
    ) u_lane (
      .clk_i     (clk_i),
      .ctl_i     (lane_ctl),
      .waddr_i   (waddr),
      .raddr_i   (raddr),
      .radius_i  (radius),
      .divisor_i (divisor),
      .sample_i  (lane_in[gi]),
      .quot_o    (lane_quo[gi])
    );
  end

  bblp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (out_ctl),
    .red_i       (lane_quo[0]),
    .green_i     (lane_quo[1]),
    .blue_i      (lane_quo[2]),
    .out_stall_i (out_stall_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
